// ----- design/otb_pkg.sv -----
// Shared types and constants for the one-shot timer bank.
package otb_pkg;

  localparam int TIMERS      = 16;
  localparam int COUNT_BITS  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ID_W        = 4;
  localparam int PERIOD_W    = 16;
  localparam int STATE_W     = 2;
  localparam int IDX_W       = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int NUM_W       = $clog2(MAX_RESULTS + 1);
  localparam int CMP_W       = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  // Command codes, equal to the mode field values.
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_RESET  = 3'd2,
    OP_DELETE = 3'd3,
    OP_SET    = 3'd4,
    OP_GET    = 3'd5
  } op_t;

  // Run state answers.
  localparam logic [STATE_W-1:0] STATE_STOPPED = 2'd0;
  localparam logic [STATE_W-1:0] STATE_INVALID = 2'd2;

  // Result kinds and status codes.
  localparam logic KIND_RESP   = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Classified command as it travels through the queue.
  typedef struct packed {
    op_t                  op;
    logic                 inbank;
    logic [IDX_W-1:0]     idx;
    logic [PERIOD_W-1:0]  period;
    logic                 new_state;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } back_state_t;

endpackage

// ----- design/otb_front.sv -----
// Front end: accepts commands, drops unused modes and classifies the index.
module otb_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_mode,
  input  logic [otb_pkg::ID_W-1:0]     in_timer_id,
  input  logic [otb_pkg::PERIOD_W-1:0] in_period,
  input  logic                         in_new_state,
  input  logic                         fifo_full,
  output logic                         push,
  output otb_pkg::cmd_t                push_cmd
);

  logic mode_ok;

  // Keep only the six defined modes.
  always_comb begin
    case (in_mode)
      otb_pkg::OP_TICK,
      otb_pkg::OP_CREATE,
      otb_pkg::OP_RESET,
      otb_pkg::OP_DELETE,
      otb_pkg::OP_SET,
      otb_pkg::OP_GET: mode_ok = 1'b1;
      default:         mode_ok = 1'b0;
    endcase
  end

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready && mode_ok;

  // Build the queued command; an index past the bank counts as unallocated.
  always_comb begin
    push_cmd.op        = otb_pkg::op_t'(in_mode);
    push_cmd.inbank    = (32'(in_timer_id) < otb_pkg::TIMERS);
    push_cmd.idx       = otb_pkg::IDX_W'(in_timer_id);
    push_cmd.period    = in_period;
    push_cmd.new_state = in_new_state;
  end

endmodule

// ----- design/otb_cmd_fifo.sv -----
// Short command queue between the front end and the timer engine.
module otb_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  otb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output otb_pkg::cmd_t pop_cmd
);

  otb_pkg::cmd_t                 mem_r [otb_pkg::FIFO_DEPTH];
  logic [otb_pkg::FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [otb_pkg::FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [otb_pkg::FIFO_AW:0]     count_r, count_nxt;

  assign full      = (count_r == (otb_pkg::FIFO_AW + 1)'(otb_pkg::FIFO_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  // Advance pointers and occupancy.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- design/otb_back.sv -----
// Timer engine: holds the timer table, runs commands and tick scans, drives results.
module otb_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pop_valid,
  input  otb_pkg::cmd_t                  pop_cmd,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic                           out_status,
  output logic [otb_pkg::STATE_W-1:0]    out_state_out,
  output logic [otb_pkg::ID_W-1:0]       out_expired_id,
  output logic                           out_last
);

  localparam logic [otb_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [otb_pkg::IDX_W-1:0]      LAST_IDX  = otb_pkg::IDX_W'(otb_pkg::TIMERS - 1);

  // Timer table.
  logic                            allocated_r [otb_pkg::TIMERS];
  logic                            running_r   [otb_pkg::TIMERS];
  logic [otb_pkg::COUNT_BITS-1:0]  count_r     [otb_pkg::TIMERS];
  logic [otb_pkg::PERIOD_W-1:0]    period_r    [otb_pkg::TIMERS];

  otb_pkg::back_state_t            state_r, state_nxt;
  logic [otb_pkg::IDX_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [otb_pkg::NUM_W-1:0]       num_r, num_nxt;
  logic                            pend_valid_r, pend_valid_nxt;
  logic [otb_pkg::IDX_W-1:0]       pend_id_r, pend_id_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_kind_r, out_status_r, out_last_r;
  logic [otb_pkg::STATE_W-1:0]     out_state_r;
  logic [otb_pkg::ID_W-1:0]        out_id_r;

  // Engine controls.
  logic                            slot_free;
  logic [otb_pkg::IDX_W-1:0]       addr;
  logic                            rd_alloc, rd_run;
  logic [otb_pkg::COUNT_BITS-1:0]  rd_count, count_inc;
  logic [otb_pkg::PERIOD_W-1:0]    rd_period;
  logic                            alloc_ok, expire, emit;
  logic                            alloc_we, alloc_val, run_we, run_val;
  logic                            count_we, period_we;
  logic [otb_pkg::COUNT_BITS-1:0]  count_val;
  logic                            out_load, ld_kind, ld_status, ld_last;
  logic [otb_pkg::STATE_W-1:0]     ld_state;
  logic [otb_pkg::ID_W-1:0]        ld_id;

  assign slot_free = !out_valid_r || out_ready;

  // Read the entry at the scan index or at the command index.
  assign addr      = (state_r == otb_pkg::ST_SCAN) ? scan_idx_r : pop_cmd.idx;
  assign rd_alloc  = allocated_r[addr];
  assign rd_run    = running_r[addr];
  assign rd_count  = count_r[addr];
  assign rd_period = period_r[addr];
  assign alloc_ok  = pop_cmd.inbank && rd_alloc;

  // Saturating increment and expiry test for the scanned entry.
  assign count_inc = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;
  assign expire    = rd_alloc && rd_run &&
                     (otb_pkg::CMP_W'(count_inc) >= otb_pkg::CMP_W'(rd_period));
  assign emit      = expire && pend_valid_r &&
                     (num_r < otb_pkg::NUM_W'(otb_pkg::MAX_RESULTS));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      otb_pkg::ST_IDLE: begin
        if (pop && pop_cmd.op == otb_pkg::OP_TICK) begin
          state_nxt = otb_pkg::ST_SCAN;
        end
      end
      otb_pkg::ST_SCAN: begin
        if (!(emit && !slot_free) && scan_idx_r == LAST_IDX) begin
          if (pend_valid_r || (expire && num_r < otb_pkg::NUM_W'(otb_pkg::MAX_RESULTS))) begin
            state_nxt = otb_pkg::ST_FLUSH;
          end else begin
            state_nxt = otb_pkg::ST_IDLE;
          end
        end
      end
      otb_pkg::ST_FLUSH: begin
        if (slot_free) begin
          state_nxt = otb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = otb_pkg::ST_IDLE;
    endcase
  end

  // Outputs: table writes, result loads and scan bookkeeping.
  always_comb begin
    pop            = 1'b0;
    alloc_we       = 1'b0;
    alloc_val      = 1'b0;
    run_we         = 1'b0;
    run_val        = 1'b0;
    count_we       = 1'b0;
    count_val      = '0;
    period_we      = 1'b0;
    out_load       = 1'b0;
    ld_kind        = otb_pkg::KIND_RESP;
    ld_status      = otb_pkg::STATUS_OK;
    ld_state       = otb_pkg::STATE_STOPPED;
    ld_id          = '0;
    ld_last        = 1'b1;
    scan_idx_nxt   = scan_idx_r;
    num_nxt        = num_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    case (state_r)
      otb_pkg::ST_IDLE: begin
        pop = pop_valid && (pop_cmd.op == otb_pkg::OP_TICK || slot_free);
        if (pop) begin
          out_load = (pop_cmd.op != otb_pkg::OP_TICK);
          ld_status = alloc_ok ? otb_pkg::STATUS_OK : otb_pkg::STATUS_FAIL;
          case (pop_cmd.op)
            otb_pkg::OP_TICK: begin
              scan_idx_nxt   = '0;
              num_nxt        = '0;
              pend_valid_nxt = 1'b0;
            end
            otb_pkg::OP_CREATE: begin
              ld_status = pop_cmd.inbank ? otb_pkg::STATUS_OK : otb_pkg::STATUS_FAIL;
              alloc_we  = pop_cmd.inbank;
              alloc_val = 1'b1;
              run_we    = pop_cmd.inbank;
              run_val   = pop_cmd.new_state;
              count_we  = pop_cmd.inbank;
              period_we = pop_cmd.inbank;
            end
            otb_pkg::OP_RESET: begin
              run_we   = alloc_ok;
              run_val  = pop_cmd.new_state;
              count_we = alloc_ok;
            end
            otb_pkg::OP_DELETE: begin
              alloc_we = alloc_ok;
              run_we   = alloc_ok;
              count_we = alloc_ok;
            end
            otb_pkg::OP_SET: begin
              run_we  = alloc_ok;
              run_val = pop_cmd.new_state;
            end
            otb_pkg::OP_GET: begin
              ld_state = alloc_ok ? {1'b0, rd_run} : otb_pkg::STATE_INVALID;
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      otb_pkg::ST_SCAN: begin
        // Hold the step while the previous event waits for a free slot.
        if (!(emit && !slot_free)) begin
          run_we       = expire;
          run_val      = 1'b0;
          count_we     = rd_alloc && rd_run;
          count_val    = count_inc;
          scan_idx_nxt = scan_idx_r + 1'b1;
          if (expire && num_r < otb_pkg::NUM_W'(otb_pkg::MAX_RESULTS)) begin
            num_nxt        = num_r + 1'b1;
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = scan_idx_r;
          end
          if (emit) begin
            out_load = 1'b1;
            ld_kind  = otb_pkg::KIND_EXPIRY;
            ld_id    = otb_pkg::ID_W'(pend_id_r);
            ld_last  = 1'b0;
          end
        end
      end
      otb_pkg::ST_FLUSH: begin
        // Send the final event with its last mark.
        if (slot_free) begin
          out_load       = 1'b1;
          ld_kind        = otb_pkg::KIND_EXPIRY;
          ld_id          = otb_pkg::ID_W'(pend_id_r);
          ld_last        = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end
      default: pop = 1'b0;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= otb_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      num_r        <= '0;
      scan_idx_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      num_r        <= num_nxt;
      scan_idx_r   <= scan_idx_nxt;
    end
  end

  // Result payload and pending event index.
  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    if (out_load) begin
      out_kind_r   <= ld_kind;
      out_status_r <= (ld_kind == otb_pkg::KIND_EXPIRY) ? otb_pkg::STATUS_OK : ld_status;
      out_state_r  <= ld_state;
      out_id_r     <= ld_id;
      out_last_r   <= ld_last;
    end
  end

  // Allocated and run marks clear at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < otb_pkg::TIMERS; i++) begin
        allocated_r[i] <= 1'b0;
        running_r[i]   <= 1'b0;
      end
    end else begin
      if (alloc_we) begin
        allocated_r[addr] <= alloc_val;
      end
      if (run_we) begin
        running_r[addr] <= run_val;
      end
    end
  end

  // Counts and periods are loaded by create before they are ever read.
  always_ff @(posedge clk) begin
    if (count_we) begin
      count_r[addr] <= count_val;
    end
    if (period_we) begin
      period_r[addr] <= pop_cmd.period;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_status     = out_status_r;
  assign out_state_out  = out_state_r;
  assign out_expired_id = out_id_r;
  assign out_last       = out_last_r;

endmodule

// ----- design/one_shot_timer_bank.sv -----
// Top level of the one-shot timer bank: front end, command queue and timer engine.
// A command response passes the command queue and the result register on its way out.
// Throughput: one command per cycle while results are taken; a tick holds the engine
// while it dispatches, scans one entry per cycle, then sends any final expiry event.
// Back-pressure on results stalls the scan only at entries that expire.
// Reset: synchronous; all timers unallocated and stopped, queue and result slot empty.
module one_shot_timer_bank (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_mode,
  input  logic [otb_pkg::ID_W-1:0]     in_timer_id,
  input  logic [otb_pkg::PERIOD_W-1:0] in_period,
  input  logic                         in_new_state,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic                         out_status,
  output logic [otb_pkg::STATE_W-1:0]  out_state_out,
  output logic [otb_pkg::ID_W-1:0]     out_expired_id,
  output logic                         out_last
);

  logic          fifo_full, push, pop, pop_valid;
  otb_pkg::cmd_t push_cmd, pop_cmd;

  otb_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_timer_id  (in_timer_id),
    .in_period    (in_period),
    .in_new_state (in_new_state),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  otb_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  otb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_cmd        (pop_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_state_out  (out_state_out),
    .out_expired_id (out_expired_id),
    .out_last       (out_last)
  );

endmodule

// ----- design/otb_checker.sv -----
// Port-level checks for the one-shot timer bank, bound to the top level.
module otb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [2:0]                   in_mode,
  input logic [otb_pkg::ID_W-1:0]     in_timer_id,
  input logic [otb_pkg::PERIOD_W-1:0] in_period,
  input logic                         in_new_state,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_kind,
  input logic                         out_status,
  input logic [otb_pkg::STATE_W-1:0]  out_state_out,
  input logic [otb_pkg::ID_W-1:0]     out_expired_id,
  input logic                         out_last
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_status)
      && $stable(out_state_out) && $stable(out_expired_id) && $stable(out_last))
    else $error("result changed while stalled");

  // Reset empties the result slot.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Every command response closes its item.
  a_resp_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == otb_pkg::KIND_RESP |-> out_last)
    else $error("command response without last");

  // Expiry events carry no status or state answer.
  a_event_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == otb_pkg::KIND_EXPIRY |->
      out_status == otb_pkg::STATUS_OK && out_state_out == otb_pkg::STATE_STOPPED)
    else $error("expiry event with status or state set");

  // An invalid state answer always comes with a failure status.
  a_invalid_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_state_out == otb_pkg::STATE_INVALID |-> out_status == otb_pkg::STATUS_FAIL)
    else $error("invalid state answered with success");

endmodule

bind one_shot_timer_bank otb_checker u_otb_checker (.*);
